// File: rtl/vct_pkg.sv
package vct_pkg;

	localparam int CHANNEL_COUNT = 16;
	localparam int IDX_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
	localparam int LIMIT_W = 5;
	localparam int AGE_W = 64;
	localparam logic [LIMIT_W-1:0] MATCH_LIMIT_RESET = 5'd3;
	localparam logic [31:0] HANDLE_FAIL = 32'hFFFF_FFFF;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		MODE_ALLOC    = 2'd0,
		MODE_FIND     = 2'd1,
		MODE_FREE     = 2'd2,
		MODE_FREE_ALL = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		KIND_FIRST      = 2'd0,
		KIND_OLDEST     = 2'd1,
		KIND_NEWEST     = 2'd2,
		KIND_OLDEST_ALL = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NONE   = 2'd1,
		ST_REJECT = 2'd2
	} status_t;

	typedef struct packed {
		mode_t        mode;
		logic [15:0]  source_object;
		logic [7:0]   channel_mask;
		logic [15:0]  sound_id;
		kind_t        search_kind;
		logic         stop_found;
		logic [31:0]  voice_handle;
		logic [3:0]   entry_index;
	} req_t;

	typedef struct packed {
		status_t      status;
		logic [3:0]   found_index;
		logic [4:0]   match_count;
		logic [31:0]  found_handle;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      handle;
		logic [15:0]      object;
		logic [7:0]       mask;
		logic [15:0]      sound;
		logic [AGE_W-1:0] age;
	} entry_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		idx_t rd_addr;
		logic free_rd;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
	} stat_t;

	function automatic logic [3:0] to_field_idx(input idx_t i);
		logic [IDX_W+3:0] t;
		t = {4'b0000, i};
		return t[3:0];
	endfunction

endpackage

// File: rtl/vct_ram.sv
module vct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic                                       rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: rtl/vct_datapath.sv
module vct_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  vct_pkg::cmd_t                     cmd,
	output vct_pkg::stat_t                    stat,
	input  vct_pkg::req_t                     request,
	input  logic                              cfg_we,
	input  logic [vct_pkg::LIMIT_W-1:0]       cfg_data,
	output logic                              done,
	output vct_pkg::rsp_t                     result
);

	localparam int CH = vct_pkg::CHANNEL_COUNT;
	localparam int IW = vct_pkg::IDX_W;
	localparam logic [vct_pkg::LIMIT_W-1:0] COUNT_MAX = '1;

	vct_pkg::req_t                    req_q;
	logic [CH-1:0]                    valid_q, valid_n;
	logic [vct_pkg::AGE_W-1:0]        age_q, age_n;
	logic [vct_pkg::LIMIT_W-1:0]      match_limit_q;
	logic                             done_q, done_n;
	logic                             found_q, found_n;
	vct_pkg::idx_t                    best_q, best_n;
	logic [vct_pkg::LIMIT_W-1:0]      count_q, count_n;
	logic [vct_pkg::AGE_W-1:0]        best_age_q, best_age_n;
	logic [31:0]                      best_handle_q, best_handle_n;
	logic                             eval_v_s1;
	vct_pkg::idx_t                    eval_idx_s1;
	logic                             result_valid_q;
	vct_pkg::rsp_t                    result_q, rsp_n;

	logic                             wr_en;
	vct_pkg::entry_t                  wr_data;
	logic [$bits(vct_pkg::entry_t)-1:0] rd_raw;
	vct_pkg::entry_t                  rec;
	vct_pkg::idx_t                    rd_addr;

	logic [IW+3:0]                    free_wide;
	vct_pkg::idx_t                    free_idx;
	logic                             free_ok;

	logic                             hit, incr, limit_hit;
	logic [vct_pkg::LIMIT_W-1:0]      cnt_inc;

	assign free_wide = {{IW{1'b0}}, req_q.entry_index};
	assign free_idx  = free_wide[IW-1:0];
	assign free_ok   = (free_wide < (IW+4)'(CH)) && valid_q[free_idx];

	assign rd_addr = cmd.free_rd ? free_idx : cmd.rd_addr;
	assign rec     = vct_pkg::entry_t'(rd_raw);

	vct_ram #(
		.WIDTH ($bits(vct_pkg::entry_t)),
		.DEPTH (CH)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (best_q),
		.wr_data (wr_data),
		.rd_en   (cmd.scan_rd | cmd.free_rd),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	// zero in a request field is a wildcard
	assign hit = valid_q[eval_idx_s1]
		&& (req_q.source_object == 16'd0 || rec.object == req_q.source_object)
		&& (req_q.channel_mask == 8'd0 || (rec.mask & req_q.channel_mask) != 8'd0)
		&& (req_q.sound_id == 16'd0 || rec.sound == req_q.sound_id);

	// count saturates; the limit only fires on a real increment
	assign incr      = count_q != COUNT_MAX;
	assign cnt_inc   = incr ? count_q + 1'b1 : count_q;
	assign limit_hit = incr && (cnt_inc == match_limit_q);

	always_comb begin
		done_n        = done_q;
		found_n       = found_q;
		best_n        = best_q;
		count_n       = count_q;
		best_age_n    = best_age_q;
		best_handle_n = best_handle_q;
		if (cmd.load) begin
			done_n        = 1'b0;
			found_n       = 1'b0;
			best_n        = '0;
			count_n       = '0;
			best_age_n    = (request.search_kind == vct_pkg::KIND_NEWEST) ? '0 : '1;
			best_handle_n = '0;
		end else if (eval_v_s1 && !done_q) begin
			if (req_q.mode == vct_pkg::MODE_ALLOC) begin
				if (!valid_q[eval_idx_s1]) begin
					found_n = 1'b1;
					best_n  = eval_idx_s1;
					done_n  = 1'b1;
				end
			end else if (hit) begin
				count_n = cnt_inc;
				case (req_q.search_kind)
					vct_pkg::KIND_FIRST: begin
						found_n       = 1'b1;
						best_n        = eval_idx_s1;
						best_handle_n = rec.handle;
						done_n        = 1'b1;
					end
					vct_pkg::KIND_NEWEST: begin
						if (rec.age > best_age_q) begin
							found_n       = 1'b1;
							best_n        = eval_idx_s1;
							best_age_n    = rec.age;
							best_handle_n = rec.handle;
						end
					end
					default: begin
						if (rec.age < best_age_q) begin
							found_n       = 1'b1;
							best_n        = eval_idx_s1;
							best_age_n    = rec.age;
							best_handle_n = rec.handle;
						end
					end
				endcase
				if (req_q.search_kind != vct_pkg::KIND_OLDEST_ALL && limit_hit) begin
					done_n = 1'b1;
				end
			end
		end
	end

	always_comb begin
		valid_n = valid_q;
		age_n   = age_q;
		wr_en   = 1'b0;
		wr_data = '{handle: req_q.voice_handle, object: req_q.source_object,
			mask: req_q.channel_mask, sound: req_q.sound_id, age: age_q};
		rsp_n   = '0;
		if (cmd.commit) begin
			case (req_q.mode)
				vct_pkg::MODE_ALLOC: begin
					if (!found_q) begin
						rsp_n.status = vct_pkg::ST_NONE;
					end else if (req_q.voice_handle == vct_pkg::HANDLE_FAIL) begin
						rsp_n.status      = vct_pkg::ST_REJECT;
						rsp_n.found_index = vct_pkg::to_field_idx(best_q);
					end else begin
						wr_en              = 1'b1;
						valid_n[best_q]    = 1'b1;
						age_n              = age_q + 1'b1;
						rsp_n.status       = vct_pkg::ST_DONE;
						rsp_n.found_index  = vct_pkg::to_field_idx(best_q);
						rsp_n.found_handle = req_q.voice_handle;
					end
				end
				vct_pkg::MODE_FIND: begin
					rsp_n.match_count = count_q;
					if (!found_q) begin
						rsp_n.status = vct_pkg::ST_NONE;
					end else begin
						rsp_n.status       = vct_pkg::ST_DONE;
						rsp_n.found_index  = vct_pkg::to_field_idx(best_q);
						rsp_n.found_handle = best_handle_q;
						if (req_q.stop_found) begin
							valid_n[best_q] = 1'b0;
						end
					end
				end
				vct_pkg::MODE_FREE: begin
					if (free_ok) begin
						valid_n[free_idx]  = 1'b0;
						rsp_n.status       = vct_pkg::ST_DONE;
						rsp_n.found_index  = vct_pkg::to_field_idx(free_idx);
						rsp_n.found_handle = rec.handle;
					end else begin
						rsp_n.status = vct_pkg::ST_NONE;
					end
				end
				vct_pkg::MODE_FREE_ALL: begin
					valid_n      = '0;
					rsp_n.status = vct_pkg::ST_DONE;
				end
				default: begin
					rsp_n.status = vct_pkg::ST_NONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q        <= '0;
			age_q          <= '0;
			match_limit_q  <= vct_pkg::MATCH_LIMIT_RESET;
			done_q         <= 1'b0;
			found_q        <= 1'b0;
			eval_v_s1      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			valid_q        <= valid_n;
			age_q          <= age_n;
			done_q         <= done_n;
			found_q        <= found_n;
			eval_v_s1      <= cmd.scan_rd;
			result_valid_q <= cmd.commit;
			if (cfg_we) begin
				match_limit_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= request;
		end
		best_q        <= best_n;
		count_q       <= count_n;
		best_age_q    <= best_age_n;
		best_handle_q <= best_handle_n;
		eval_idx_s1   <= cmd.rd_addr;
		if (cmd.commit) begin
			result_q <= rsp_n;
		end
	end

	assign stat.scan_done = done_q;
	assign done           = result_valid_q;
	assign result         = result_q;

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |=> !result_valid_q)
		else $error("result strobe held for more than one cycle");

	a_find_hit_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && req_q.mode == vct_pkg::MODE_FIND && found_q)
		|=> (result_q.status == vct_pkg::ST_DONE && result_q.match_count != '0))
		else $error("selected match reported without count");

	a_alloc_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> valid_q[$past(best_q)])
		else $error("allocated entry not marked valid");

	a_count_all_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(eval_v_s1 && req_q.mode == vct_pkg::MODE_FIND
		&& req_q.search_kind == vct_pkg::KIND_OLDEST_ALL && !cmd.load) |=> !done_q)
		else $error("count-all search stopped early");

endmodule

// File: rtl/vct_ctrl.sv
module vct_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  vct_pkg::mode_t  mode,
	input  vct_pkg::stat_t  stat,
	output vct_pkg::cmd_t   cmd,
	output logic            busy
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FREE_RD,
		S_FIN
	} state_t;

	localparam vct_pkg::idx_t LAST = vct_pkg::idx_t'(vct_pkg::CHANNEL_COUNT - 1);

	state_t        state_q;
	vct_pkg::idx_t cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						if (mode inside {vct_pkg::MODE_ALLOC, vct_pkg::MODE_FIND}) begin
							state_q <= S_SCAN;
						end else if (mode == vct_pkg::MODE_FREE) begin
							state_q <= S_FREE_RD;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					// an early stop leaves at most two reads in flight, which are ignored
					if (stat.scan_done) begin
						state_q <= S_FIN;
					end else if (cnt_q == LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_FIN;
				end
				S_FREE_RD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd.load    = (state_q == S_IDLE) && start;
	assign cmd.scan_rd = (state_q == S_SCAN);
	assign cmd.rd_addr = cnt_q;
	assign cmd.free_rd = (state_q == S_FREE_RD);
	assign cmd.commit  = (state_q == S_FIN);
	assign busy        = (state_q != S_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && cnt_q == LAST && !stat.scan_done) |=> state_q == S_DRAIN)
		else $error("scan did not drain after last entry");

	a_fin_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN) |=> (state_q == S_IDLE))
		else $error("commit lasted more than one cycle");

endmodule

// File: rtl/voice_channel_table_core.sv
// allocate and find walk the entries, then strobe the result; an early stop ends the walk sooner
// (a read per entry, a drain state, a commit state); free one: read, commit; free all: commit
// a request is taken in the strobe cycle, so a new one waits until the last one is done
// the walk is set by the single read port of the entry ram, one entry a cycle
// reset clears the valid bits, the age counter and sets match_limit to 3; entry ram is not reset
// the result is shown for one cycle with done high; the receiver cannot stall
module voice_channel_table_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  vct_pkg::req_t                request,
	output logic                         done,
	output vct_pkg::rsp_t                result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [vct_pkg::LIMIT_W-1:0]  cfg_data
);

	vct_pkg::cmd_t  cmd;
	vct_pkg::stat_t stat;

	assign cfg_ready = !busy;

	vct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (request.mode),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	vct_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.request  (request),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

endmodule
